/* rtl/sff_pkg.sv */
package sff_pkg;

   // delay line
   localparam int RING_DEPTH = 1024;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   // tap table
   localparam int MAX_TAPS = 16;
   localparam int TAP_AW   = $clog2(MAX_TAPS);
   localparam int TAP_CW   = TAP_AW + 1;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int LAG_W    = 10;
   localparam int SLOT_W   = 4;
   localparam int TAP_W    = SAMPLE_W + LAG_W;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int ACC_W    = 40;
   localparam int FRAC_W   = 15;

   // register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] ADDR_TAPS_IN_USE = CSR_AW'(0);
   localparam logic [TAP_CW-1:0] TAPS_RESET       = TAP_CW'(1);

   // commands
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef struct packed {
      logic                       command;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [SLOT_W-1:0]          tap_slot;
      logic signed [SAMPLE_W-1:0] tap_weight;
      logic [LAG_W-1:0]           tap_lag;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } rsp_type;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;   // new sample accepted, zero the accumulator
      logic valid;   // one tap beat reaches the unit
      logic add;     // beat carries a real product
      logic last;    // final tap of this sample
   } mac_ctl_type;

endpackage

/* rtl/sparse_fir_filter.sv */
// Sparse FIR filter, one sample per beat, Q1.15 data, 40-bit accumulator.
// A sample beat issues max(N,1) tap beats, N = min(taps_in_use, 16), one
// delay line read per tap; each beat passes the tap table read, delay line read,
// product and accumulate registers. Samples do not overlap: the next beat is
// accepted only once the result has left the accumulator. A tap load gives no result.
// Synchronous active-high reset: delay line reads as zero, taps_in_use = 1.
module sparse_fir_filter (
   input  logic                         clock,
   input  logic                         reset,
   // sample / tap load channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sff_pkg::req_type             req_data,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sff_pkg::rsp_type             rsp_data,
   // register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sff_pkg::CSR_AW-1:0]   paddr,
   input  logic [sff_pkg::CSR_DW-1:0]   pwdata,
   output logic [sff_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   import sff_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [TAP_CW-1:0]  taps_ff, taps_in;          // taps_in_use register
   logic [RING_AW-1:0] wp_ff, wp_in;              // write pointer
   logic [RING_AW:0]   fill_ff, fill_in;          // entries written since reset
   logic [RING_AW-1:0] newest_ff, newest_in;      // slot of the current sample
   logic [TAP_AW-1:0]  tidx_ff, tidx_in;          // tap being issued
   logic [TAP_AW-1:0]  tlast_ff, tlast_in;        // last tap index to issue
   logic               has_taps_ff, has_taps_in;  // N > 0
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // tap pipeline: s1 = tap table data back, s2 = delay line data back
   logic               s1_vld_ff, s1_add_ff, s1_last_ff;
   logic               s2_vld_ff, s2_add_ff, s2_last_ff;
   logic               s2_live_ff, s2_live_in;
   logic signed [SAMPLE_W-1:0] s2_weight_ff;

   // datapath
   logic               accept, take_sample, take_load, issue, issue_last;
   logic               csr_wr, finish;
   logic [TAP_CW-1:0]  taps_sat;
   logic [TAP_W-1:0]   tap_rdata;
   logic [SAMPLE_W-1:0] dly_rdata;
   logic [RING_AW-1:0] s1_lag, s1_pos;
   logic signed [SAMPLE_W-1:0] s2_sample;
   mac_ctl_type        mac_ctl;
   logic               mac_done;
   rsp_type            mac_result;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid & req_ready;
   assign take_sample = accept & (req_data.command == CMD_FILTER);
   assign take_load   = accept & (req_data.command == CMD_LOAD);

   assign issue      = (state_ff == ST_RUN);
   assign issue_last = issue & (tidx_ff == tlast_ff);

   // result may leave the accumulator once the output slot is free
   assign finish = (state_ff == ST_WAIT) & mac_done & (~rsp_valid_ff | rsp_ready);

   // register port: no wait states
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   assign prdata = (paddr == ADDR_TAPS_IN_USE) ? CSR_DW'(taps_ff) : '0;

   // more than MAX_TAPS taps clamps
   assign taps_sat = (taps_ff > TAP_CW'(MAX_TAPS)) ? TAP_CW'(MAX_TAPS) : taps_ff;

   // tap table: {weight, lag}, written by load beats, read once per issued tap
   sff_ram #(
      .WIDTH (TAP_W),
      .DEPTH (MAX_TAPS)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (take_load),
      .wr_addr (req_data.tap_slot[TAP_AW-1:0]),
      .wr_data ({req_data.tap_weight, req_data.tap_lag}),
      .rd_addr (tidx_ff),
      .rd_data (tap_rdata)
   );

   // s1: index back from the newest by the lag, modulo the ring depth
   assign s1_lag = RING_AW'(tap_rdata[LAG_W-1:0]);
   assign s1_pos = newest_ff - s1_lag;
   // slots past the fill count were never written and read as zero
   assign s2_live_in = ({1'b0, s1_pos} < fill_ff);

   // delay line: written on sample accept, read once per tap
   sff_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_dly_ram (
      .clock   (clock),
      .wr_en   (take_sample),
      .wr_addr (wp_ff),
      .wr_data (req_data.sample_in),
      .rd_addr (s1_pos),
      .rd_data (dly_rdata)
   );

   // s2: operands to the multiply-accumulate unit
   assign s2_sample = s2_live_ff ? $signed(dly_rdata) : '0;

   always_comb begin
      mac_ctl.clear = take_sample;
      mac_ctl.valid = s2_vld_ff;
      mac_ctl.add   = s2_add_ff;
      mac_ctl.last  = s2_last_ff;
   end

   sff_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .weight (s2_weight_ff),
      .sample (s2_sample),
      .done   (mac_done),
      .result (mac_result)
   );

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      taps_in     = taps_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      newest_in   = newest_ff;
      tidx_in     = tidx_ff;
      tlast_in    = tlast_ff;
      has_taps_in = has_taps_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in      = rsp_ff;

      if (csr_wr && paddr == ADDR_TAPS_IN_USE) begin
         taps_in = pwdata[TAP_CW-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (take_sample) begin
               state_in  = ST_RUN;
               newest_in = wp_ff;
               wp_in     = wp_ff + RING_AW'(1);
               if (fill_ff != (RING_AW+1)'(RING_DEPTH)) begin
                  fill_in = fill_ff + (RING_AW+1)'(1);
               end
               tidx_in     = '0;
               has_taps_in = (taps_sat != '0);
               // zero taps still sends one empty beat to close the sum
               tlast_in    = (taps_sat == '0) ? '0 : TAP_AW'(taps_sat - TAP_CW'(1));
            end
         end
         ST_RUN: begin
            tidx_in = tidx_ff + TAP_AW'(1);
            if (issue_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = mac_result;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taps_ff      <= TAPS_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s1_add_ff    <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s2_add_ff    <= 1'b0;
         s2_last_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taps_ff      <= taps_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= issue;
         s1_add_ff    <= issue & has_taps_ff;
         s1_last_ff   <= issue_last;
         s2_vld_ff    <= s1_vld_ff;
         s2_add_ff    <= s1_add_ff;
         s2_last_ff   <= s1_last_ff;
      end
      newest_ff    <= newest_in;
      tidx_ff      <= tidx_in;
      tlast_ff     <= tlast_in;
      has_taps_ff  <= has_taps_in;
      rsp_ff       <= rsp_in;
      s2_live_ff   <= s2_live_in;
      s2_weight_ff <= $signed(tap_rdata[TAP_W-1:LAG_W]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/sff_ram.sv */
module sff_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sff_mac.sv */
module sff_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  sff_pkg::mac_ctl_type                ctl,
   input  logic signed [sff_pkg::SAMPLE_W-1:0] weight,
   input  logic signed [sff_pkg::SAMPLE_W-1:0] sample,
   output logic                                done,
   output sff_pkg::rsp_type                    result
);

   import sff_pkg::*;

   // product stage
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff, prod_last_ff;
   // accumulate stage
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     done_ff, done_in;
   logic                     sat_same;
   logic [ACC_W-1:0]         acc_bits;

   always_comb begin
      prod_in = ctl.add ? PROD_W'(weight * sample) : '0;
      if (ctl.clear) begin
         acc_in  = '0;
         done_in = 1'b0;
      end else if (prod_vld_ff) begin
         acc_in  = acc_ff + ACC_W'(prod_ff);
         done_in = done_ff | prod_last_ff;
      end else begin
         acc_in  = acc_ff;
         done_in = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         prod_vld_ff  <= ctl.valid & ~ctl.clear;
         prod_last_ff <= ctl.last;
         done_ff      <= done_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // floor shift by FRAC_W is a bit slice; it fits 16 bits when the
   // upper bits all match the new sign bit
   assign acc_bits = acc_ff;
   assign sat_same = (acc_bits[ACC_W-1:FRAC_W+SAMPLE_W-1] == '0) ||
                     (acc_bits[ACC_W-1:FRAC_W+SAMPLE_W-1] == '1);

   always_comb begin
      result.clipped = ~sat_same;
      if (sat_same) begin
         result.filtered = acc_bits[FRAC_W+SAMPLE_W-1:FRAC_W];
      end else if (acc_bits[ACC_W-1]) begin
         result.filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         result.filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   assign done = done_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import sff_pkg::*;

   // Pause after draining; covers the longest sample (16 taps) with margin.
   localparam int SETTLE_CYCLES = 32;
   // Cycles with no beat on any port before the run is declared hung.
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 141;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [CSR_AW-1:0]   paddr     = '0;
   logic [CSR_DW-1:0]   pwdata    = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // Stimulus and scoreboard state
   req_type             feed_q[$];
   rsp_type             expected_outputs[$];
   logic                req_taken   = 1'b0;  // beat accepted at the last rising edge
   bit                  steady      = 1'b0;  // no idling on either side while set
   int                  quiet_cycles = 0;
   int                  error_count  = 0;

   // Filter shadow state: delay line, write pointer, tap table, tap count
   logic signed [SAMPLE_W-1:0] ring_model[RING_DEPTH] = '{default: '0};
   logic [RING_AW-1:0]         head_model  = '0;
   logic signed [SAMPLE_W-1:0] weight_model[MAX_TAPS];
   logic [LAG_W-1:0]           lag_model[MAX_TAPS];
   logic [TAP_CW-1:0]          taps_model  = TAPS_RESET;

   sparse_fir_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Load beats update the tap table; sample beats push into the delay line and
   // produce one expected output: sum of weight * delayed sample, floor >> 15,
   // clamped to 16 bits.
   function automatic void step_filter_model(req_type item);
      rsp_type                    out;
      logic signed [ACC_W-1:0]    acc;
      logic signed [ACC_W-1:0]    scaled;
      logic signed [PROD_W-1:0]   product;
      logic [RING_AW-1:0]         newest;
      logic [RING_AW-1:0]         pos;
      int                         n;
      if (item.command == CMD_LOAD) begin
         weight_model[item.tap_slot] = item.tap_weight;
         lag_model[item.tap_slot]    = item.tap_lag;
         return;
      end
      newest             = head_model;
      ring_model[newest] = item.sample_in;
      head_model         = newest + 1'b1;
      // tap counts above the table size clamp to the table size
      n   = (taps_model > MAX_TAPS) ? MAX_TAPS : int'(taps_model);
      acc = '0;
      for (int t = 0; t < n; t++) begin
         pos     = newest - lag_model[t];   // ring wrap via 10-bit arithmetic
         product = weight_model[t] * ring_model[pos];
         acc     = acc + product;
      end
      scaled      = acc >>> FRAC_W;
      out.clipped = 1'b0;
      if (scaled > 32767) begin
         out.filtered = 16'sh7FFF;
         out.clipped  = 1'b1;
      end else if (scaled < -32768) begin
         out.filtered = 16'sh8000;
         out.clipped  = 1'b1;
      end else begin
         out.filtered = scaled[SAMPLE_W-1:0];
      end
      expected_outputs.push_back(out);
   endfunction

   // Biased toward full scale, zero and small magnitudes
   function automatic logic [SAMPLE_W-1:0] random_word();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return '0;
         3: return SAMPLE_W'($urandom_range(0, 127)) - SAMPLE_W'(64);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [LAG_W-1:0] random_lag();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return LAG_W'(RING_DEPTH - 1);
         2: return LAG_W'($urandom_range(0, 15));
         default: return LAG_W'($urandom_range(0, RING_DEPTH - 1));
      endcase
   endfunction

   // Fields a beat does not use are randomized so every bit toggles.
   function automatic req_type tap_load(int slot, logic [SAMPLE_W-1:0] weight,
                                        logic [LAG_W-1:0] lag);
      req_type item;
      item.command    = CMD_LOAD;
      item.sample_in  = SAMPLE_W'($urandom);
      item.tap_slot   = SLOT_W'(slot);
      item.tap_weight = weight;
      item.tap_lag    = lag;
      return item;
   endfunction

   function automatic req_type sample_beat(logic [SAMPLE_W-1:0] value);
      req_type item;
      item.command    = CMD_FILTER;
      item.sample_in  = value;
      item.tap_slot   = SLOT_W'($urandom);
      item.tap_weight = SAMPLE_W'($urandom);
      item.tap_lag    = LAG_W'($urandom);
      return item;
   endfunction

   // Wait for the pipeline to drain, then let any trailing load retire.
   task automatic wait_idle();
      while (feed_q.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: holds a beat until taken, idles ~15% unless steady.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (feed_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
            req_data  <= feed_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result backpressure
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 15);
   end

   // Monitor: predict on request beats, check on result beats
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            step_filter_model(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               $error("output beat with nothing outstanding: filtered %0d clipped %0b",
                      rsp_data.filtered, rsp_data.clipped);
               error_count++;
            end else begin
               rsp_type exp_out;
               exp_out = expected_outputs.pop_front();
               if (rsp_data.filtered !== exp_out.filtered) begin
                  $error("filtered: expected %0d, actual %0d",
                         exp_out.filtered, rsp_data.filtered);
                  error_count++;
               end
               if (rsp_data.clipped !== exp_out.clipped) begin
                  $error("clipped: expected %0b, actual %0b",
                         exp_out.clipped, rsp_data.clipped);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // Stimulus
   initial begin
      logic [TAP_CW-1:0] setting;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single tap (reset count) with full-scale weights, lags 0 and
      // max; -1 * -1 saturates high. Then fill the rest of the tap table so
      // every later tap count reads only written entries.
      feed_q.push_back(tap_load(0, 16'h7FFF, '0));
      feed_q.push_back(sample_beat(16'h7FFF));
      feed_q.push_back(sample_beat(16'h8000));
      feed_q.push_back(tap_load(0, 16'h8000, '0));
      feed_q.push_back(sample_beat(16'h8000));
      feed_q.push_back(sample_beat(16'h7FFF));
      feed_q.push_back(tap_load(0, 16'h8000, LAG_W'(RING_DEPTH - 1)));
      feed_q.push_back(sample_beat('0));
      for (int s = 1; s < MAX_TAPS; s++)
         feed_q.push_back(tap_load(s, (s % 2) ? 16'h8000 : 16'h7FFF,
                                   (s == MAX_TAPS - 1) ? LAG_W'(RING_DEPTH - 1)
                                                       : LAG_W'(s)));
      feed_q.push_back(sample_beat(16'h8000));

      // Random phases, one tap count each: full table, zero, single, over-range, random
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       setting = TAP_CW'(MAX_TAPS);
            1:       setting = '0;
            2:       setting = TAP_CW'(1);
            3:       setting = '1;
            4:       setting = TAP_CW'($urandom_range(2, MAX_TAPS - 1));
            5:       setting = TAP_CW'(MAX_TAPS + 1);
            6:       setting = TAP_CW'($urandom);
            default: setting = TAP_CW'(MAX_TAPS);
         endcase
         wait_idle();
         steady = 1'b0;

         // register write, then read back
         @(negedge clock);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= ADDR_TAPS_IN_USE;
         pwdata  <= CSR_DW'(setting);
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         taps_model = setting;
         @(negedge clock);
         penable <= 1'b0;
         pwrite  <= 1'b0;
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         if (prdata !== CSR_DW'(setting)) begin
            $error("taps_in_use: expected %0d, actual %0d", setting, prdata);
            error_count++;
         end
         @(negedge clock);
         psel    <= 1'b0;
         penable <= 1'b0;

         // last phase runs without any idling on either side
         steady = (p == PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 10)
               feed_q.push_back(tap_load($urandom_range(0, MAX_TAPS - 1),
                                         random_word(), random_lag()));
            else
               feed_q.push_back(sample_beat(random_word()));
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
